// ----- design/rc5tx_pkg.sv -----
package rc5tx_pkg;

  localparam int PAYLOAD_W   = 32;
  localparam int BIT_COUNT_W = 6;
  localparam int HALF_W      = 16;
  localparam int CARRIER_W   = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_BITS_DEF = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HIGH   = 2'd2;

  // Register values after reset: 889 us half bits and a 36 kHz carrier at
  // one third duty, for a 16 MHz clock.
  localparam logic [HALF_W-1:0]    HALF_BIT_TICKS_RST = 16'd14224;
  localparam logic [CARRIER_W-1:0] CARRIER_PERIOD_RST = 10'd444;
  localparam logic [CARRIER_W-1:0] CARRIER_HIGH_RST   = 10'd148;

  typedef struct packed {
    logic                   req_type;
    logic [PAYLOAD_W-1:0]   payload;
    logic [BIT_COUNT_W-1:0] bit_count;
    logic                   extended;
  } in_t;

  typedef struct packed {
    logic ir_out;
    logic envelope;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } out_t;

  typedef struct packed {
    logic [HALF_W-1:0]    half_bit_ticks;
    logic [CARRIER_W-1:0] carrier_period;
    logic [CARRIER_W-1:0] carrier_high;
  } cfg_t;

endpackage

// ----- design/rc5tx_core.sv -----
module rc5tx_core
  import rc5tx_pkg::*;
#(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  localparam int HW = $clog2(2 * MAX_BITS + 3);
  localparam logic [BIT_COUNT_W-1:0] MAX_N = BIT_COUNT_W'(MAX_BITS);

  logic                 sending_r, sending_nxt;
  logic [MAX_BITS-1:0]  bit_shift_r, bit_shift_nxt;
  logic [HW-1:0]        halves_left_r, halves_left_nxt;
  logic [HALF_W-1:0]    half_timer_r, half_timer_nxt;
  logic [CARRIER_W-1:0] carrier_count_r, carrier_count_nxt;
  logic                 mark_level_r, mark_level_nxt;
  logic                 start_pend_r, start_pend_nxt;
  logic                 start_ext_r, start_ext_nxt;

  logic                 load;
  logic [BIT_COUNT_W-1:0] n_sat;
  logic [HALF_W:0]      timer_inc;
  logic [CARRIER_W:0]   carrier_inc;
  logic [HW-1:0]        halves_dec;
  logic                 bit_val;
  logic                 done;

  always_comb begin
    load  = item.req_type && !sending_r;
    n_sat = (item.bit_count > MAX_N) ? MAX_N : item.bit_count;

    sending_nxt     = sending_r;
    bit_shift_nxt   = bit_shift_r;
    halves_left_nxt = halves_left_r;
    half_timer_nxt  = half_timer_r;
    mark_level_nxt  = mark_level_r;
    start_pend_nxt  = start_pend_r;
    start_ext_nxt   = start_ext_r;
    done            = 1'b0;
    bit_val         = 1'b0;
    halves_dec      = '0;

    // A frame starts with its first mark half on the accepting tick.
    if (load) begin
      bit_shift_nxt   = item.payload[MAX_BITS-1:0] << (MAX_N - n_sat);
      halves_left_nxt = (HW'(n_sat) << 1) + HW'(2);
      half_timer_nxt  = '0;
      mark_level_nxt  = 1'b1;
      start_pend_nxt  = 1'b1;
      start_ext_nxt   = item.extended;
      sending_nxt     = 1'b1;
    end

    result.busy_res = sending_nxt;
    result.accepted = load;
    result.envelope = sending_nxt && mark_level_nxt;
    result.ir_out   = sending_nxt && mark_level_nxt && (carrier_count_r < cfg.carrier_high);

    timer_inc = {1'b0, half_timer_nxt} + (HALF_W + 1)'(1);
    if (sending_nxt) begin
      if (timer_inc >= {1'b0, cfg.half_bit_ticks}) begin
        half_timer_nxt = '0;
        if (halves_left_nxt == '0) begin
          sending_nxt    = 1'b0;
          mark_level_nxt = 1'b0;
          done           = 1'b1;
        end else begin
          halves_dec      = halves_left_nxt - HW'(1);
          halves_left_nxt = halves_dec;
          if (halves_dec[0]) begin
            // First half of a new bit: a one is space then mark.
            if (start_pend_nxt) begin
              bit_val        = !start_ext_nxt;
              start_pend_nxt = 1'b0;
            end else begin
              bit_val       = bit_shift_nxt[MAX_BITS-1];
              bit_shift_nxt = bit_shift_nxt << 1;
            end
            mark_level_nxt = !bit_val;
          end else begin
            mark_level_nxt = !mark_level_nxt;
          end
        end
      end else begin
        half_timer_nxt = timer_inc[HALF_W-1:0];
      end
    end
    result.frame_done = done;

    carrier_inc       = {1'b0, carrier_count_r} + (CARRIER_W + 1)'(1);
    carrier_count_nxt = (carrier_inc >= {1'b0, cfg.carrier_period}) ? '0
                                                                     : carrier_inc[CARRIER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r       <= 1'b0;
      bit_shift_r     <= '0;
      halves_left_r   <= '0;
      half_timer_r    <= '0;
      carrier_count_r <= '0;
      mark_level_r    <= 1'b0;
      start_pend_r    <= 1'b0;
      start_ext_r     <= 1'b0;
    end else if (step) begin
      sending_r       <= sending_nxt;
      bit_shift_r     <= bit_shift_nxt;
      halves_left_r   <= halves_left_nxt;
      half_timer_r    <= half_timer_nxt;
      carrier_count_r <= carrier_count_nxt;
      mark_level_r    <= mark_level_nxt;
      start_pend_r    <= start_pend_nxt;
      start_ext_r     <= start_ext_nxt;
    end
  end

endmodule

// ----- design/rc5_ir_transmitter_top.sv -----
// RC5 infrared transmitter with extended start bit and carrier modulation.
// Every request on the input channel is one clock tick of the transmitter:
// either a plain tick (req_type 0) or a send request carrying the payload,
// the bit count and the extended flag. Every request yields exactly one
// result on the output channel with the drive level, the envelope, the busy
// flag, whether a send request started a frame, and a frame-done strobe.
// A send request that arrives while a frame is still going out is dropped
// and shows accepted low with busy high.
// The result of an accepted request is registered: a request accepted at one edge
// has its result valid after that edge. Throughput is one request per cycle while the
// receiver does not stall, set by the single result register behind the next-state logic.
// When the receiver stalls, the result register holds its value and
// in_ready drops, so the timer state only advances on accepted requests.
// Synchronous reset returns the frame state to idle, clears the carrier
// counter, empties the result register and loads the default half-bit length,
// carrier period and carrier high time. Configuration writes take effect on
// the next request and should be made while the block is idle.
module rc5_ir_transmitter_top
  import rc5tx_pkg::*;
#(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t result;
  logic accept;

  // The result register may be refilled in the same cycle it is drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Register file; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks <= HALF_BIT_TICKS_RST;
      cfg_r.carrier_period <= CARRIER_PERIOD_RST;
      cfg_r.carrier_high   <= CARRIER_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HALF_BIT_TICKS: cfg_r.half_bit_ticks <= cfg_wdata[HALF_W-1:0];
        REG_CARRIER_PERIOD: cfg_r.carrier_period <= cfg_wdata[CARRIER_W-1:0];
        REG_CARRIER_HIGH:   cfg_r.carrier_high   <= cfg_wdata[CARRIER_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sequencer and carrier; it advances one tick per accepted request.
  rc5tx_core #(
    .MAX_BITS(MAX_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .item  (in_data),
    .cfg   (cfg_r),
    .result(result)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/rc5tx_checker.sv -----
module rc5tx_checker
  import rc5tx_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input out_t out_data,
  input logic out_valid,
  input logic out_ready
);

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every accepted request shows its result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // A stalled result blocks new requests.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drive, start and end flags only appear inside a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.envelope || out_data.accepted || out_data.frame_done)
      |-> out_data.busy_res && (out_data.envelope || !out_data.ir_out))
    else $error("frame flags outside a frame");

endmodule

bind rc5_ir_transmitter_top rc5tx_checker u_rc5tx_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_data (out_data),
  .out_valid(out_valid),
  .out_ready(out_ready)
);

// ----- dv/testbench.sv -----
// Checks the RC5 transmitter one tick at a time. Every request carries one
// clock tick of the transmitter, and every accepted request is run through a
// local copy of the frame and carrier logic to get the one result it must
// produce. Results are compared field by field, oldest first.
module testbench;
  import rc5tx_pkg::*;

  // Index with no register behind it. Writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  // After this many results the receiver stops taking them for a while, so
  // that the result register fills and in_ready has to drop.
  localparam int HOLD_AT_RESULT = 450;
  localparam int HOLD_CYCLES    = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rc5_ir_transmitter_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Ticks waiting to be offered, and the results they are known to produce.
  in_t  pend_ticks[$];
  out_t exp_levels[$];

  // When quiet is set, neither side idles.
  logic quiet = 1'b0;
  int   bad_count = 0;
  int   cycle_count = 0;

  // Local copy of the register file, loaded with the reset values.
  logic [HALF_W-1:0]    half_len = HALF_BIT_TICKS_RST;
  logic [CARRIER_W-1:0] car_per  = CARRIER_PERIOD_RST;
  logic [CARRIER_W-1:0] car_hi   = CARRIER_HIGH_RST;

  // Local copy of the frame state: idle after reset.
  logic                 tx_active     = 1'b0;
  logic [PAYLOAD_W-1:0] shreg         = '0;
  logic [6:0]           halves        = '0;
  logic [HALF_W-1:0]    htimer        = '0;
  logic [CARRIER_W-1:0] ccount        = '0;
  logic                 mark          = 1'b0;
  logic                 start_pending = 1'b0;
  logic                 start_xt      = 1'b0;

  // Advances the local transmitter by one tick and gives the result that tick
  // shows. A send request only starts a frame when the line is idle, and its
  // first mark half begins on the accepting tick itself.
  task automatic rc5_step(input in_t it, output out_t r);
    int n;
    int nxt;
    logic cur_bit;
    logic [63:0] wide;
    r = '0;
    if (it.req_type && !tx_active) begin
      n = it.bit_count;
      // Counts beyond the payload width saturate.
      if (n > MAX_BITS_DEF) n = MAX_BITS_DEF;
      // Left-align the low n payload bits so they leave from bit 31.
      wide = {32'd0, it.payload} << (32 - n);
      shreg = (n == 0) ? '0 : wide[31:0];
      halves = 2 + 2 * n;
      htimer = '0;
      mark = 1'b1;
      start_pending = 1'b1;
      start_xt = it.extended;
      tx_active = 1'b1;
      r.accepted = 1'b1;
    end
    r.busy_res = tx_active;
    r.envelope = tx_active && mark;
    r.ir_out   = tx_active && mark && (ccount < car_hi);
    if (tx_active) begin
      nxt = htimer + 1;
      // A half length of zero ends a half on every tick.
      if (nxt >= half_len) begin
        htimer = '0;
        if (halves == 0) begin
          tx_active = 1'b0;
          mark = 1'b0;
          r.frame_done = 1'b1;
        end else begin
          halves = halves - 1;
          if (halves[0]) begin
            // First half of a new bit; the second start bit goes first.
            if (start_pending) begin
              cur_bit = !start_xt;
              start_pending = 1'b0;
            end else begin
              cur_bit = shreg[31];
              shreg = shreg << 1;
            end
            mark = !cur_bit;
          end else begin
            mark = !mark;
          end
        end
      end else begin
        htimer = nxt[15:0];
      end
    end
    // The carrier runs whether or not a frame is going out. A counter past a
    // newly shortened period wraps on its next step.
    nxt = ccount + 1;
    ccount = (nxt >= car_per) ? '0 : nxt[9:0];
  endtask

  // Driver: offers pending ticks, holding each one until it is taken.
  always @(posedge clk) begin
    out_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rc5_step(in_data, pred);
        exp_levels.push_back(pred);
      end
      if (!in_valid || in_ready) begin
        if (pend_ticks.size() != 0 && (quiet || $urandom_range(0, 99) >= 33)) begin
          in_valid <= 1'b1;
          in_data  <= pend_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int   rx_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  out_t want;

  // The one long hold-off, counted in cycles once enough results are in.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rx_count >= HOLD_AT_RESULT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: takes results and compares them with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_count++;
        if (exp_levels.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $write("result %0d arrived with nothing expected: ", rx_count);
            $display("ir=%b env=%b busy=%b acc=%b done=%b",
                     out_data.ir_out, out_data.envelope, out_data.busy_res,
                     out_data.accepted, out_data.frame_done);
          end
        end else begin
          want = exp_levels.pop_front();
          if (out_data.ir_out !== want.ir_out || out_data.envelope !== want.envelope ||
              out_data.busy_res !== want.busy_res || out_data.accepted !== want.accepted ||
              out_data.frame_done !== want.frame_done) begin
            bad_count++;
            if (bad_count <= 10) begin
              $write("result %0d: expected ir=%b env=%b busy=%b acc=%b done=%b, ",
                     rx_count, want.ir_out, want.envelope, want.busy_res, want.accepted,
                     want.frame_done);
              $display("got ir=%b env=%b busy=%b acc=%b done=%b",
                       out_data.ir_out, out_data.envelope, out_data.busy_res,
                       out_data.accepted, out_data.frame_done);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // A run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_item(input logic req, input logic [PAYLOAD_W-1:0] payload,
                          input logic [BIT_COUNT_W-1:0] bc, input logic ext);
    in_t it;
    it.req_type  = req;
    it.payload   = payload;
    it.bit_count = bc;
    it.extended  = ext;
    pend_ticks.push_back(it);
  endtask

  // Plain ticks; the unused fields carry random junk that must be ignored.
  task automatic add_ticks(input int count);
    int k;
    for (k = 0; k < count; k++)
      add_item(1'b0, $urandom, $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  // Mostly well-formed traffic: a send request, then about as many ticks as
  // the frame needs for the half length h, so the next request tends to find
  // the line idle. Some frames are cut short by an early request, and a few
  // stray requests land in the middle of a frame.
  task automatic gen_frames(input int count, input int h);
    int made;
    int n;
    int n_eff;
    int est;
    int span;
    int k;
    made = 0;
    while (made < count) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
      add_item(1'b1, $urandom, n[5:0], $urandom_range(0, 1));
      made++;
      n_eff = (n > MAX_BITS_DEF) ? MAX_BITS_DEF : n;
      est = (3 + 2 * n_eff) * ((h == 0) ? 1 : h);
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, est) : est + $urandom_range(0, 3);
      for (k = 0; k < span && made < count; k++) begin
        add_item($urandom_range(0, 19) == 0, $urandom, $urandom_range(0, 63),
                 $urandom_range(0, 1));
        made++;
      end
    end
  endtask

  // Register writes go out on consecutive edges; the local copy is updated
  // right away, since nothing is in flight while they happen.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HALF_BIT_TICKS: half_len = val;
      REG_CARRIER_PERIOD: car_per  = val[CARRIER_W-1:0];
      REG_CARRIER_HIGH:   car_hi   = val[CARRIER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] p,
                         input logic [CFG_DATA_W-1:0] hi);
    write_reg(REG_HALF_BIT_TICKS, h);
    write_reg(REG_CARRIER_PERIOD, p);
    write_reg(REG_CARRIER_HIGH, hi);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every tick has been taken and every result checked, then
  // lets the pipeline settle.
  task automatic drain();
    while (pend_ticks.size() != 0 || in_valid || exp_levels.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  int h_rand;

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // A few ticks on the reset register values, with the line idle.
    add_ticks(3);
    drain();

    // Directed frames with one tick per half (a half length of zero), so
    // each frame is short enough to follow by hand.
    set_cfg(16'd0, 16'd4, 16'd2);
    add_item(1'b0, 32'hFFFF_FFFF, 6'd63, 1'b1);
    // A frame of the two start bits alone, plain second start bit.
    add_item(1'b1, 32'h0000_0000, 6'd0, 1'b0);
    // A send while that frame is still going out is dropped.
    add_item(1'b1, 32'hFFFF_FFFF, 6'd32, 1'b1);
    add_ticks(2);
    // The same with the extended second start bit.
    add_item(1'b1, 32'hFFFF_FFFF, 6'd0, 1'b1);
    add_ticks(2);
    // One payload bit of each value.
    add_item(1'b1, 32'h0000_0001, 6'd1, 1'b0);
    add_ticks(4);
    add_item(1'b1, 32'hFFFF_FFFE, 6'd1, 1'b1);
    add_ticks(4);
    add_item(1'b1, 32'hAAAA_AAAA, 6'd2, 1'b1);
    add_ticks(6);
    drain();

    // Carrier period zero keeps the counter at zero, so the carrier is
    // always on with any nonzero high time.
    set_cfg(16'd0, 16'd0, 16'd1);
    gen_frames(90, 0);
    drain();

    // Longest carrier period with no high time: marks never drive the line.
    set_cfg(16'd1, 16'd1023, 16'd0);
    gen_frames(90, 1);
    drain();

    // A stretch with no idling on either side. The carrier registers get
    // junk in the bits above their width.
    quiet = 1'b1;
    set_cfg(16'd2, {6'($urandom), 10'd3}, {6'($urandom), 10'd1});
    gen_frames(100, 2);
    drain();
    quiet = 1'b0;

    // High time at the period: the carrier is always high.
    h_rand = $urandom_range(1, 4);
    set_cfg(h_rand[15:0], 16'd2, 16'd2);
    gen_frames(100, h_rand);
    drain();

    // Start a frame with the longest half length, then shorten the half and
    // the carrier period while it is going out. The carrier counter is past
    // the new period and has to wrap. A write to the unused index follows.
    set_cfg(16'hFFFF, 16'd1023, 16'd300);
    add_item(1'b1, $urandom, 6'd5, $urandom_range(0, 1));
    add_ticks(40);
    drain();
    write_reg(REG_HALF_BIT_TICKS, 16'd3);
    write_reg(REG_CARRIER_PERIOD, 16'd5);
    write_reg(REG_UNUSED, 16'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_frames(110, 3);
    drain();

    set_cfg(16'd4, 16'd7, 16'd3);
    gen_frames(90, 4);
    drain();

    repeat (10) @(posedge clk);
    if (bad_count == 0 && exp_levels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rc5tx_pkg.sv
design/rc5tx_core.sv
design/rc5_ir_transmitter_top.sv
design/rc5tx_checker.sv
dv/testbench.sv
